>>> rtl/core/command_line_tokenizer_assert.svh
// Assertion macros shared by the tokenizer modules
`ifndef COMMAND_LINE_TOKENIZER_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_ASSERT_SVH

// Checked on every rising edge of clk, ignored while reset is applied.
`define CLT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define CLT_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/clt_pkg.sv
// Types, codes and helpers of the command line tokenizer
package clt_pkg;

	localparam int unsigned CH_W      = 8;
	localparam int unsigned LEN_W     = 12;
	localparam int unsigned DEPTH_W   = 13;
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [LEN_W-1:0]   LEN_MAX         = '1;
	localparam logic [DEPTH_W-1:0] BR_DEPTH_MAX    = '1;
	localparam logic [LEN_W-1:0]   MAX_TOKEN_RESET = 12'd255;

	localparam logic [CH_W-1:0] CH_NUL       = 8'h00;
	localparam logic [CH_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [CH_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CH_W-1:0] CH_CR        = 8'h0d;
	localparam logic [CH_W-1:0] CH_HASH      = 8'h23;
	localparam logic [CH_W-1:0] CH_DQUOTE    = 8'h22;
	localparam logic [CH_W-1:0] CH_SQUOTE    = 8'h27;
	localparam logic [CH_W-1:0] CH_LBRACKET  = 8'h5b;
	localparam logic [CH_W-1:0] CH_RBRACKET  = 8'h5d;
	localparam logic [CH_W-1:0] CH_BACKSLASH = 8'h5c;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef enum logic [1:0] {
		FORM_PLAIN  = 2'd0,
		FORM_DQ     = 2'd1,
		FORM_SQ     = 2'd2,
		FORM_BR     = 2'd3
	} token_form_t;

	typedef enum logic [2:0] {
		MODE_BETWEEN = 3'd0,
		MODE_PLAIN   = 3'd1,
		MODE_DQ      = 3'd2,
		MODE_SQ      = 3'd3,
		MODE_BR      = 3'd4,
		MODE_IGNORE  = 3'd5,
		MODE_DQ_CUT  = 3'd6,
		MODE_SQ_CUT  = 3'd7
	} parse_mode_t;

	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            end_of_line;
	} item_t;

	typedef struct packed {
		logic            kind;
		logic [CH_W-1:0] token_byte;
		logic [1:0]      token_form;
	} result_t;

	// One accepted item's worth of output: one or two results
	typedef struct packed {
		logic    two;
		result_t r0;
		result_t r1;
	} record_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	function automatic logic [1:0] form_of(input parse_mode_t mode);
		logic [1:0] f;
		unique case (mode)
			MODE_DQ: f = FORM_DQ;
			MODE_SQ: f = FORM_SQ;
			MODE_BR: f = FORM_BR;
			default: f = FORM_PLAIN;
		endcase
		return f;
	endfunction

	function automatic logic is_ws(input logic [CH_W-1:0] b);
		return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
	endfunction

endpackage

>>> rtl/core/clt_front.sv
// Front end: takes bytes, tracks token state, builds result records
module clt_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [11:0]      cfg_wr_data,
	input  logic             take,
	input  clt_pkg::item_t   item,
	output logic             rec_push,
	output clt_pkg::record_t rec
);
	import clt_pkg::*;

	logic [LEN_W-1:0]   max_chars_q;
	parse_mode_t        mode_q, mode_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [DEPTH_W-1:0] dep_q, dep_d;
	logic               esc_q, esc_d;
	logic               any_d;

	logic [CH_W-1:0]    b;
	logic               closes;
	logic [LEN_W-1:0]   lim;
	logic [LEN_W-1:0]   st_len;
	logic               st_full;
	parse_mode_t        st_cut_mode;
	result_t            byte_res, end_res;
	logic [DEPTH_W-1:0] br_dep;
	logic               no_token;

	// outcome of handling the byte from a cleared state
	parse_mode_t        start_mode;
	logic [DEPTH_W-1:0] start_dep;
	logic               start_store;
	logic               start_cut;
	result_t            start_byte_res, start_end_res;

	assign b      = item.ch;
	assign closes = item.end_of_line || (b == CH_NUL);
	assign lim    = (max_chars_q == '0) ? LEN_W'(1) : max_chars_q;

	assign st_len  = (len_q == LEN_MAX) ? len_q : len_q + LEN_W'(1);
	assign st_full = st_len >= lim;
	assign st_cut_mode = (mode_q == MODE_DQ) ? MODE_DQ_CUT :
		(mode_q == MODE_SQ) ? MODE_SQ_CUT : MODE_BETWEEN;

	assign byte_res = '{kind: KIND_BYTE, token_byte: b, token_form: form_of(mode_q)};
	assign end_res  = '{kind: KIND_END, token_byte: CH_NUL, token_form: form_of(mode_q)};

	assign br_dep = (b == CH_LBRACKET) ?
			((dep_q == BR_DEPTH_MAX) ? dep_q : dep_q + DEPTH_W'(1)) :
		(b == CH_RBRACKET) ?
			((dep_q == '0) ? dep_q : dep_q - DEPTH_W'(1)) : dep_q;

	assign start_byte_res = '{kind: KIND_BYTE, token_byte: b, token_form: FORM_PLAIN};
	assign start_end_res  = '{kind: KIND_END, token_byte: CH_NUL, token_form: FORM_PLAIN};
	assign start_cut      = lim == LEN_W'(1);

	// no token open: between tokens, ignored text or just after a cut
	assign no_token = (mode_q == MODE_BETWEEN) || (mode_q >= MODE_IGNORE);

	always_comb begin
		start_dep   = '0;
		start_store = 1'b0;
		priority if (is_ws(b)) begin
			start_mode = MODE_BETWEEN;
		end else if (b == CH_HASH || b == CH_RBRACKET) begin
			start_mode = MODE_IGNORE;
		end else if (b == CH_DQUOTE) begin
			start_mode = MODE_DQ;
		end else if (b == CH_SQUOTE) begin
			start_mode = MODE_SQ;
		end else if (b == CH_LBRACKET) begin
			start_mode = MODE_BR;
			start_dep  = DEPTH_W'(1);
		end else begin
			start_mode  = start_cut ? MODE_BETWEEN : MODE_PLAIN;
			start_store = 1'b1;
		end
	end

	always_comb begin
		mode_d  = mode_q;
		len_d   = len_q;
		dep_d   = dep_q;
		esc_d   = esc_q;
		any_d   = 1'b0;
		rec.two = 1'b0;
		rec.r0  = end_res;
		rec.r1  = end_res;
		if (closes) begin
			any_d  = (mode_q == MODE_PLAIN) || (mode_q == MODE_DQ) ||
				(mode_q == MODE_SQ) || (mode_q == MODE_BR);
			mode_d = MODE_BETWEEN;
			len_d  = '0;
			dep_d  = '0;
			esc_d  = 1'b0;
		end else begin
			unique case (mode_q)
				MODE_IGNORE: begin
				end
				MODE_BETWEEN, MODE_DQ_CUT, MODE_SQ_CUT: begin
					// a quote right after a cut quoted token is swallowed
					if ((mode_q == MODE_DQ_CUT && b == CH_DQUOTE) ||
						(mode_q == MODE_SQ_CUT && b == CH_SQUOTE)) begin
						mode_d = MODE_BETWEEN;
						len_d  = '0;
						dep_d  = '0;
						esc_d  = 1'b0;
					end else begin
						mode_d  = start_mode;
						len_d   = (start_store && !start_cut) ? LEN_W'(1) : '0;
						dep_d   = start_dep;
						esc_d   = 1'b0;
						any_d   = start_store;
						rec.r0  = start_byte_res;
						rec.r1  = start_end_res;
						rec.two = start_store && start_cut;
					end
				end
				MODE_PLAIN, MODE_DQ, MODE_SQ, MODE_BR: begin
					any_d = 1'b1;
					priority if (mode_q == MODE_PLAIN && is_ws(b)) begin
						mode_d = MODE_BETWEEN;
						len_d  = '0;
					end else if (mode_q == MODE_PLAIN && (b == CH_HASH ||
						b == CH_LBRACKET || b == CH_RBRACKET)) begin
						// token ends, the byte then opens or ignores as between tokens
						mode_d = start_mode;
						len_d  = '0;
						dep_d  = start_dep;
					end else if (mode_q == MODE_DQ && !esc_q && b == CH_DQUOTE) begin
						mode_d = MODE_BETWEEN;
						len_d  = '0;
						esc_d  = 1'b0;
					end else if (mode_q == MODE_SQ && b == CH_SQUOTE) begin
						mode_d = MODE_BETWEEN;
						len_d  = '0;
					end else if (mode_q == MODE_BR && br_dep == '0) begin
						mode_d = MODE_BETWEEN;
						len_d  = '0;
						dep_d  = '0;
					end else begin
						// store the byte, cut the token when it is full
						rec.r0 = byte_res;
						if (mode_q == MODE_BR) begin
							dep_d = br_dep;
						end
						if (st_full) begin
							rec.two = 1'b1;
							mode_d  = st_cut_mode;
							len_d   = '0;
							dep_d   = '0;
							esc_d   = 1'b0;
						end else begin
							len_d = st_len;
							esc_d = (mode_q == MODE_DQ) && !esc_q && (b == CH_BACKSLASH);
						end
					end
				end
			endcase
		end
	end

	assign rec_push = take && any_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_chars_q <= MAX_TOKEN_RESET;
		end else if (cfg_wr_en) begin
			max_chars_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_BETWEEN;
			len_q  <= '0;
			dep_q  <= '0;
			esc_q  <= 1'b0;
		end else if (take) begin
			mode_q <= mode_d;
			len_q  <= len_d;
			dep_q  <= dep_d;
			esc_q  <= esc_d;
		end
	end

	`include "command_line_tokenizer_assert.svh"

	`CLT_ASSERT(a_esc_only_in_dq, esc_q |-> (mode_q == MODE_DQ), "escape outside double quotes")
	`CLT_ASSERT(a_depth_only_in_br, (dep_q != '0) |-> (mode_q == MODE_BR), "depth outside brackets")
	`CLT_ASSERT(a_len_zero_idle, no_token |-> (len_q == '0), "length kept outside a token")

endmodule

>>> rtl/core/clt_queue.sv
// Short record queue between front and back ends
module clt_queue #(
	parameter int unsigned DEPTH = clt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  clt_pkg::record_t     wr_rec,
	input  logic                 pop,
	output clt_pkg::record_t     rd_rec,
	output clt_pkg::q_status_t   status
);
	import clt_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	record_t          slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign status.empty = cnt_q == '0;
	assign status.full  = cnt_q == CNT_FULL;
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign rd_rec  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	`include "command_line_tokenizer_assert.svh"

	`CLT_ASSERT_ALWAYS(a_cnt_bound, !arst_n || (cnt_q <= CNT_FULL), "queue count over depth")
	`CLT_ASSERT(a_no_push_full, !(push && status.full), "push into full queue")

endmodule

>>> rtl/core/clt_back.sv
// Back end: unpacks records into single results behind an output register
module clt_back (
	input  logic             clk,
	input  logic             arst_n,
	input  clt_pkg::q_status_t q_status,
	input  clt_pkg::record_t rd_rec,
	output logic             q_pop,
	output logic             empty,
	input  logic             pop,
	output clt_pkg::result_t result
);
	import clt_pkg::*;

	result_t out_q, sec_q;
	logic    out_valid_q, sec_valid_q;
	logic    slot_free;

	assign slot_free = !out_valid_q || pop;
	assign q_pop     = slot_free && !sec_valid_q && !q_status.empty;
	assign empty     = !out_valid_q;
	assign result    = out_q;

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (sec_valid_q) begin
				out_q <= sec_q;
			end else if (q_pop) begin
				out_q <= rd_rec.r0;
				sec_q <= rd_rec.r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sec_valid_q <= 1'b0;
		end else if (slot_free) begin
			if (sec_valid_q) begin
				out_valid_q <= 1'b1;
				sec_valid_q <= 1'b0;
			end else begin
				out_valid_q <= q_pop;
				sec_valid_q <= q_pop && rd_rec.two;
			end
		end
	end

	`include "command_line_tokenizer_assert.svh"

	`CLT_ASSERT(a_sec_needs_out, sec_valid_q |-> out_valid_q, "second result without first")
	`CLT_ASSERT(a_end_is_zero, (out_valid_q && out_q.kind == KIND_END) |-> (out_q.token_byte == CH_NUL), "end of token with nonzero byte")

endmodule

>>> rtl/core/command_line_tokenizer.sv
// Top level of the command line tokenizer: front end, record queue, back end
// A result passes the record queue and then the output register before its pop.
// Throughput: one item per cycle in while full is low; one result per cycle out
//   with pop held, so an item that yields a byte and an end of token needs two pops.
// full follows the record queue only; the output register and the second-result
//   slot let items flow in while a result waits to be popped.
// Reset (arst_n low, asynchronous): between tokens, queue and outputs empty,
//   max_token_chars back to 255.
module command_line_tokenizer #(
	parameter int unsigned QUEUE_DEPTH = clt_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// configuration: max_token_chars
	input  logic             cfg_wr_en,
	input  logic [11:0]      cfg_wr_data,
	// item side
	input  logic             push,
	output logic             full,
	input  clt_pkg::item_t   item,
	// result side
	output logic             empty,
	input  logic             pop,
	output clt_pkg::result_t result
);
	import clt_pkg::*;

	record_t   wr_rec, rd_rec;
	logic      rec_push, q_pop;
	q_status_t q_status;
	logic      take;

	// An item is taken whenever the queue has room; items that yield no
	// result (whitespace, ignored text) only move the parse state.
	assign full = q_status.full;
	assign take = push && !q_status.full;

	// Front: byte classification and token state, one item per cycle unless full
	clt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.take       (take),
		.item       (item),
		.rec_push   (rec_push),
		.rec        (wr_rec)
	);

	// Queue of records, one record per item that yields results
	clt_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rec_push),
		.wr_rec(wr_rec),
		.pop   (q_pop),
		.rd_rec(rd_rec),
		.status(q_status)
	);

	// Back: hands out one result at a time
	clt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_status(q_status),
		.rd_rec  (rd_rec),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule
